@@ hw/rtl/dlaa_pkg.sv @@
// ----------------------------------------------------------------------------
// dlaa_pkg
// Shared types and constants of the late-acceptance acceptor: ring control
// word, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package dlaa_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HIST_LEN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 1'd1;

    // fixed register and counter widths
    localparam int HIST_LEN_W     = 7;
    localparam int IDLE_W         = 32;
    localparam int HIST_LEN_RESET = 64;

    // control broadcast to every cell of the history ring
    typedef struct packed {
        logic fill;  // load the fill value into every cell in use
        logic rot;   // shift the ring by one cell towards the head
    } t_ring_ctl;

endpackage

@@ hw/rtl/dlaa_cell.sv @@
// ----------------------------------------------------------------------------
// dlaa_cell
// One history slot of the ring. Loads the fill value or takes the word of
// its neighbour (or the wrapped head word at the tail) on a rotation.
// ----------------------------------------------------------------------------
module dlaa_cell
    import dlaa_pkg::*;
#(
    parameter int COST_WIDTH = 32,
    parameter int LEN_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_ring_ctl             i_ctl,
    input  logic [LEN_W-1:0]      i_ring_len,
    input  logic [LEN_W-1:0]      i_fill_len,
    input  logic [COST_WIDTH-1:0] i_fill_value,
    input  logic [COST_WIDTH-1:0] i_next,
    input  logic [COST_WIDTH-1:0] i_wrap,
    output logic [COST_WIDTH-1:0] o_value
);

    localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(INDEX);

    logic [COST_WIDTH-1:0] r_value;
    logic [COST_WIDTH-1:0] n_value;
    logic                  in_ring;
    logic                  in_fill;
    logic                  is_tail;

    assign in_ring = MY_IDX < i_ring_len;
    assign in_fill = MY_IDX < i_fill_len;
    assign is_tail = MY_IDX == (i_ring_len - LEN_W'(1));

    always_comb begin
        n_value = r_value;
        if (i_ctl.fill && in_fill) begin
            n_value = i_fill_value;
        end else if (i_ctl.rot && in_ring) begin
            n_value = is_tail ? i_wrap : i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ hw/rtl/dlaa_ring.sv @@
// ----------------------------------------------------------------------------
// dlaa_ring
// Row of history cells forming a rotating ring; the head cell holds the slot
// under the slot pointer whenever the ring is aligned.
// ----------------------------------------------------------------------------
module dlaa_ring
    import dlaa_pkg::*;
#(
    parameter int HIST_DEPTH = 64,
    parameter int COST_WIDTH = 32,
    parameter int LEN_W      = 7
) (
    input  logic                  i_clk,
    input  t_ring_ctl             i_ctl,
    input  logic [LEN_W-1:0]      i_ring_len,
    input  logic [LEN_W-1:0]      i_fill_len,
    input  logic [COST_WIDTH-1:0] i_fill_value,
    input  logic [COST_WIDTH-1:0] i_tail_value,
    output logic [COST_WIDTH-1:0] o_head
);

    logic [COST_WIDTH-1:0] w_value [HIST_DEPTH];

    for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
        logic [COST_WIDTH-1:0] w_next;
        if (k == HIST_DEPTH - 1) begin : g_last
            assign w_next = i_tail_value;
        end else begin : g_mid
            assign w_next = w_value[k+1];
        end

        dlaa_cell #(
            .COST_WIDTH (COST_WIDTH),
            .LEN_W      (LEN_W),
            .INDEX      (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_ring_len   (i_ring_len),
            .i_fill_len   (i_fill_len),
            .i_fill_value (i_fill_value),
            .i_next       (w_next),
            .i_wrap       (i_tail_value),
            .o_value      (w_value[k])
        );
    end

    assign o_head = w_value[0];

endmodule

@@ hw/rtl/diversified_late_acceptance_acceptor.sv @@
// A word is accepted in the idle state; the update state then does the read-modify-write
// of the ring head cell, and the result is registered from that state, or from the output
// state while the output stalls. A new word is taken only back in idle. A rescan of the
// history maximum turns the ring once through the head, and after a change of
// history_length the ring realigns before the next word is taken.
// Reset is synchronous: control state clears, history is undefined until a start.
// ----------------------------------------------------------------------------
// diversified_late_acceptance_acceptor
// Acceptance engine for diversified late-acceptance search with a history
// ring built as a chain of cells.
// ----------------------------------------------------------------------------
module diversified_late_acceptance_acceptor
    import dlaa_pkg::*;
#(
    parameter int HIST_DEPTH = 64,
    parameter int COST_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [COST_WIDTH-1:0] i_cost,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_accepted,
    output logic                  o_improved_best,
    output logic [COST_WIDTH-1:0] o_best_cost,
    output logic [COST_WIDTH-1:0] o_current_cost,
    output logic                  o_done_res
);

    localparam int LEN_W = $clog2(HIST_DEPTH + 1);
    localparam int IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CMP_W = (LEN_W > HIST_LEN_W) ? LEN_W : HIST_LEN_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // configuration registers
    logic [HIST_LEN_W-1:0] r_hist_len;
    logic [IDLE_W-1:0]     r_idle_limit;

    // control state
    logic [1:0]            r_state,      n_state;
    logic [IDX_W-1:0]      r_slot,       n_slot;
    logic [LEN_W-1:0]      r_off,        n_off;
    logic [LEN_W-1:0]      r_ring_len,   n_ring_len;
    logic [COST_WIDTH-1:0] r_present,    n_present;
    logic [COST_WIDTH-1:0] r_lowest,     n_lowest;
    logic [COST_WIDTH-1:0] r_hmax,       n_hmax;
    logic [LEN_W-1:0]      r_mcnt,       n_mcnt;
    logic [IDLE_W-1:0]     r_idle_cnt,   n_idle_cnt;
    logic                  r_fin,        n_fin;
    logic                  r_active,     n_active;
    logic                  r_out_valid;

    // payload
    logic [COST_WIDTH-1:0] r_prev,       n_prev;
    logic                  r_acc,        n_acc;
    logic                  r_imp,        n_imp;
    logic [LEN_W-1:0]      r_scan_cnt,   n_scan_cnt;
    logic [COST_WIDTH-1:0] r_scan_max,   n_scan_max;
    logic [LEN_W-1:0]      r_scan_num,   n_scan_num;
    logic                  r_o_acc;
    logic                  r_o_imp;
    logic [COST_WIDTH-1:0] r_o_best;
    logic [COST_WIDTH-1:0] r_o_cur;
    logic                  r_o_done;

    // datapath
    logic [CMP_W-1:0]      hl_ext;
    logic [LEN_W-1:0]      len_used;
    logic [LEN_W-1:0]      slot_ext;
    logic [LEN_W-1:0]      p_len;
    logic [LEN_W-1:0]      p_inc;
    logic [LEN_W-1:0]      off_inc;
    logic                  aligned;
    logic                  in_acc;
    logic                  out_free;
    logic                  emit;
    t_ring_ctl             ring_ctl;
    logic [COST_WIDTH-1:0] tail_value;
    logic [COST_WIDTH-1:0] w_head;

    logic                  c_acc;
    logic [COST_WIDTH-1:0] c_present;
    logic                  c_imp;
    logic [COST_WIDTH-1:0] c_lowest;
    logic [IDLE_W-1:0]     c_idle;
    logic                  c_fin;

    logic [COST_WIDTH-1:0] u_head;
    logic [LEN_W-1:0]      u_mcnt;
    logic                  u_rescan;

    logic [COST_WIDTH-1:0] s_max;
    logic [LEN_W-1:0]      s_num;

    assign hl_ext = CMP_W'(r_hist_len);

    always_comb begin
        if (hl_ext == '0) begin
            len_used = LEN_W'(1);
        end else if (hl_ext > CMP_W'(HIST_DEPTH)) begin
            len_used = LEN_W'(HIST_DEPTH);
        end else begin
            len_used = LEN_W'(hl_ext);
        end
    end

    // slot pointer beyond the length in use falls back to slot zero
    assign slot_ext = LEN_W'(r_slot);
    assign p_len    = (slot_ext < len_used) ? slot_ext : '0;
    assign p_inc    = ((p_len + LEN_W'(1)) >= len_used) ? '0 : p_len + LEN_W'(1);
    assign off_inc  = ((r_off + LEN_W'(1)) == r_ring_len) ? '0 : r_off + LEN_W'(1);

    assign aligned    = (r_ring_len == len_used) && (r_off == p_len);
    assign o_in_ready = (r_state == ST_IDLE) && aligned;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // candidate acceptance against current cost and history maximum
    always_comb begin
        c_acc     = (i_cost == r_present) || (i_cost < r_hmax);
        c_present = c_acc ? i_cost : r_present;
        c_imp     = c_present < r_lowest;
        c_lowest  = c_imp ? c_present : r_lowest;
        if (c_imp) begin
            c_idle = '0;
        end else if (r_idle_cnt != '1) begin
            c_idle = r_idle_cnt + IDLE_W'(1);
        end else begin
            c_idle = r_idle_cnt;
        end
        c_fin = (c_lowest == '0) ||
                ((r_idle_limit != '0) && (c_idle >= r_idle_limit));
    end

    // head slot update after the acceptance decision
    always_comb begin
        u_head   = w_head;
        u_mcnt   = r_mcnt;
        u_rescan = 1'b0;
        if (w_head < r_present) begin
            u_head = r_present;
        end else if ((w_head > r_present) && (r_prev > r_present)) begin
            u_head = r_present;
            if ((w_head == r_hmax) && (r_mcnt != '0)) begin
                u_mcnt = r_mcnt - LEN_W'(1);
            end
            u_rescan = (u_mcnt == '0);
        end
    end

    // running maximum and occurrence count for the rescan
    always_comb begin
        s_max = r_scan_max;
        s_num = r_scan_num;
        if (w_head > r_scan_max) begin
            s_max = w_head;
            s_num = LEN_W'(1);
        end else if (w_head == r_scan_max) begin
            s_num = r_scan_num + LEN_W'(1);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_off      = r_off;
        n_ring_len = r_ring_len;
        n_present  = r_present;
        n_lowest   = r_lowest;
        n_hmax     = r_hmax;
        n_mcnt     = r_mcnt;
        n_idle_cnt = r_idle_cnt;
        n_fin      = r_fin;
        n_active   = r_active;
        n_prev     = r_prev;
        n_acc      = r_acc;
        n_imp      = r_imp;
        n_scan_cnt = r_scan_cnt;
        n_scan_max = r_scan_max;
        n_scan_num = r_scan_num;
        ring_ctl   = '0;
        tail_value = w_head;
        emit       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!aligned) begin
                    // realign: back to offset zero, switch length, then on to the slot
                    if ((r_ring_len != len_used) && (r_off == '0)) begin
                        n_ring_len = len_used;
                    end else begin
                        ring_ctl.rot = 1'b1;
                        n_off        = off_inc;
                    end
                end else if (in_acc) begin
                    n_state  = ST_UPD;
                    n_active = 1'b0;
                    if (!i_func) begin
                        ring_ctl.fill = 1'b1;
                        n_off         = '0;
                        n_slot        = '0;
                        n_present     = i_cost;
                        n_lowest      = i_cost;
                        n_hmax        = i_cost;
                        n_mcnt        = len_used;
                        n_idle_cnt    = '0;
                        n_fin         = (i_cost == '0);
                        n_acc         = 1'b1;
                        n_imp         = 1'b0;
                    end else if (!r_fin) begin
                        n_prev     = r_present;
                        n_present  = c_present;
                        n_lowest   = c_lowest;
                        n_idle_cnt = c_idle;
                        n_fin      = c_fin;
                        n_acc      = c_acc;
                        n_imp      = c_imp;
                        n_active   = 1'b1;
                    end else begin
                        n_acc = 1'b0;
                        n_imp = 1'b0;
                    end
                end
            end

            ST_UPD: begin
                n_active = 1'b0;
                if (r_active) begin
                    ring_ctl.rot = 1'b1;
                    tail_value   = u_head;
                    n_off        = off_inc;
                    n_slot       = IDX_W'(p_inc);
                    n_mcnt       = u_mcnt;
                end
                if (r_active && u_rescan) begin
                    n_scan_cnt = '0;
                    n_scan_max = '0;
                    n_scan_num = '0;
                    n_state    = ST_SCAN;
                end else if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_OUT;
                end
            end

            ST_SCAN: begin
                // one full turn of the ring through the head cell
                ring_ctl.rot = 1'b1;
                n_off        = off_inc;
                n_scan_max   = s_max;
                n_scan_num   = s_num;
                n_scan_cnt   = r_scan_cnt + LEN_W'(1);
                if (r_scan_cnt == (r_ring_len - LEN_W'(1))) begin
                    n_hmax  = s_max;
                    n_mcnt  = s_num;
                    n_state = ST_OUT;
                end
            end

            ST_OUT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    dlaa_ring #(
        .HIST_DEPTH (HIST_DEPTH),
        .COST_WIDTH (COST_WIDTH),
        .LEN_W      (LEN_W)
    ) u_ring (
        .i_clk        (i_clk),
        .i_ctl        (ring_ctl),
        .i_ring_len   (r_ring_len),
        .i_fill_len   (len_used),
        .i_fill_value (i_cost),
        .i_tail_value (tail_value),
        .o_head       (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_len   <= HIST_LEN_W'(HIST_LEN_RESET);
            r_idle_limit <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HIST_LEN:   r_hist_len   <= i_cfg_data[HIST_LEN_W-1:0];
                CFG_IDLE_LIMIT: r_idle_limit <= i_cfg_data[IDLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_slot     <= '0;
            r_off      <= '0;
            r_ring_len <= LEN_W'(HIST_DEPTH);
            r_present  <= '0;
            r_lowest   <= '0;
            r_hmax     <= '0;
            r_mcnt     <= '0;
            r_idle_cnt <= '0;
            r_fin      <= 1'b1;
            r_active   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_slot     <= n_slot;
            r_off      <= n_off;
            r_ring_len <= n_ring_len;
            r_present  <= n_present;
            r_lowest   <= n_lowest;
            r_hmax     <= n_hmax;
            r_mcnt     <= n_mcnt;
            r_idle_cnt <= n_idle_cnt;
            r_fin      <= n_fin;
            r_active   <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev     <= n_prev;
        r_acc      <= n_acc;
        r_imp      <= n_imp;
        r_scan_cnt <= n_scan_cnt;
        r_scan_max <= n_scan_max;
        r_scan_num <= n_scan_num;
    end

    // output register parts the two sides
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_acc  <= r_acc;
            r_o_imp  <= r_imp;
            r_o_best <= r_lowest;
            r_o_cur  <= r_present;
            r_o_done <= r_fin;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_o_acc;
    assign o_improved_best = r_o_imp;
    assign o_best_cost     = r_o_best;
    assign o_current_cost  = r_o_cur;
    assign o_done_res      = r_o_done;

endmodule

@@ hw/rtl/dlaa_checker.sv @@
// ----------------------------------------------------------------------------
// dlaa_checker
// Port-level checks of the acceptor's results, bound to the top level.
// ----------------------------------------------------------------------------
module dlaa_checker
    import dlaa_pkg::*;
#(
    parameter int COST_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  logic                  o_accepted,
    input  logic                  o_improved_best,
    input  logic [COST_WIDTH-1:0] o_best_cost,
    input  logic [COST_WIDTH-1:0] o_current_cost,
    input  logic                  o_done_res
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_best_cost) &&
        $stable(o_current_cost) && $stable(o_accepted) && $stable(o_done_res))
        else $error("result word changed while stalled");

    // a new best can only come from an accepted candidate
    a_imp_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_improved_best |-> o_accepted)
        else $error("best improved without acceptance");

    a_imp_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_improved_best |-> o_best_cost == o_current_cost)
        else $error("new best differs from current cost");

    a_best_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_best_cost <= o_current_cost)
        else $error("best cost above current cost");

    a_zero_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_best_cost == '0) |-> o_done_res)
        else $error("zero best cost without done");

endmodule

bind diversified_late_acceptance_acceptor dlaa_checker #(
    .COST_WIDTH (COST_WIDTH)
) u_dlaa_checker (.*);
